@@ src/stereo_feedback_delay_assert.svh @@
// ----------------------------------------------------------------------------
// stereo_feedback_delay_assert.svh
// Assertion macros used by the stereo feedback delay lane RTL. They sample on
// clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_ASSERT_SVH

// Same-cycle implication.
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and arithmetic helpers of the stereo feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int LINE_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int DELAY_W    = 12;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int FB_W       = PROD_W - GAIN_FRAC;
  localparam int SUM_W      = FB_W + 1;
  localparam int SMP_MAX    = 2 ** (SAMPLE_W - 1) - 1;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic [DELAY_W-1:0]         delay_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_DELAY    = 2'd0,
    CFG_RIGHT_DELAY   = 2'd1,
    CFG_FEEDBACK_GAIN = 2'd2
  } cfg_reg_e;

  // Control shared by both lanes.
  typedef struct packed {
    logic  advance;   // pipeline moves this cycle
    logic  accept;    // a new word enters this cycle
    addr_t wr_ptr;    // line entry of the word entering now
    addr_t fill;      // words written so far, saturating
  } lane_ctl_t;

  typedef struct packed {
    logic    valid;
    sample_t sample;
  } lane_res_t;

  // A zero delay acts as one; a delay past the line acts as the longest.
  function automatic addr_t eff_delay(input delay_t d);
    int unsigned dw;
    dw = 32'(d);
    if (dw == 0) return addr_t'(1);
    if (dw >= LINE_DEPTH) return addr_t'(LINE_DEPTH - 1);
    return addr_t'(dw);
  endfunction

  // Clamp a widened sum to the signed sample range.
  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(SMP_MAX);
    lo = ~hi;
    if (v > hi) return sample_t'(hi);
    if (v < lo) return sample_t'(lo);
    return sample_t'(v);
  endfunction

endpackage

`default_nettype wire

@@ src/sfd_lane.sv @@
// ----------------------------------------------------------------------------
// sfd_lane
// One channel of the delay: delay line memory, read forwarding, feedback
// multiply and the saturating sums.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_lane import sfd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lane_ctl_t ctl,
  input  wire delay_t    delay,
  input  wire gain_t     gain,
  input  wire sample_t   dry_in,
  output lane_res_t      res
);

`include "stereo_feedback_delay_assert.svh"

  logic [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0] mem_q_r;

  addr_t   d_eff;
  addr_t   rd_addr;

  logic    s1_vld_r;
  sample_t s1_dry_r;
  addr_t   s1_ra_r;
  addr_t   s1_wp_r;
  logic    s1_zero_r;
  logic    s1_byp_hit_r;
  sample_t s1_byp_val_r;

  logic                     s2_vld_r;
  sample_t                  s2_dry_r;
  addr_t                    s2_wp_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  sample_t                  s2_half_r;

  sample_t                  delayed;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [SUM_W-1:0]  fb_sum;
  logic signed [SUM_W-1:0]  out_sum;
  sample_t                  wr_val;

  assign d_eff   = eff_delay(delay);
  assign rd_addr = ctl.wr_ptr - d_eff;

  // Value written back by the word in the last stage. The upper product bits
  // are the floored feedback term and keep their sign.
  assign fb_sum = SUM_W'(s2_dry_r) + SUM_W'($signed(s2_prod_r[PROD_W-1:GAIN_FRAC]));
  assign wr_val = sat_sample(fb_sum);
  assign out_sum = SUM_W'(s2_dry_r) + SUM_W'(s2_half_r);

  // The delayed sample may still be in flight: take it from the last stage,
  // from a write that raced the memory read, or as zero if never written.
  always_comb begin
    if (s2_vld_r && (s2_wp_r == s1_ra_r)) begin
      delayed = wr_val;
    end else if (s1_byp_hit_r) begin
      delayed = s1_byp_val_r;
    end else if (s1_zero_r) begin
      delayed = '0;
    end else begin
      delayed = sample_t'(mem_q_r);
    end
  end

  assign prod_c = PROD_W'(gain) * PROD_W'(delayed);

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      mem_q_r <= line_mem[rd_addr];
      if (s2_vld_r) begin
        line_mem[s2_wp_r] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (ctl.advance) begin
      s1_vld_r <= ctl.accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      s1_dry_r     <= dry_in;
      s1_ra_r      <= rd_addr;
      s1_wp_r      <= ctl.wr_ptr;
      s1_zero_r    <= (ctl.fill < d_eff);
      s1_byp_hit_r <= s2_vld_r && (s2_wp_r == rd_addr);
      s1_byp_val_r <= wr_val;
      s2_dry_r     <= s1_dry_r;
      s2_wp_r      <= s1_wp_r;
      s2_prod_r    <= prod_c;
      s2_half_r    <= delayed >>> 1;
    end
  end

  assign res.valid  = s2_vld_r;
  assign res.sample = sat_sample(out_sum);

  `SFD_ASSERT_NOW(a_adjacent, s1_vld_r && s2_vld_r, s1_wp_r == s2_wp_r + 1'b1, "out of order")
  `SFD_ASSERT_NOW(a_zero_no_byp, s1_vld_r && s1_zero_r, !s1_byp_hit_r, "bad forward")
  `SFD_ASSERT_NEXT(a_stall, !ctl.advance && s2_vld_r, s2_vld_r && $stable(s2_wp_r), "stall slip")

endmodule

`default_nettype wire

@@ src/sfd_merge.sv @@
// ----------------------------------------------------------------------------
// sfd_merge
// Joins the two lane results into one output word and holds it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_merge import sfd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lane_res_t             left_res,
  input  wire lane_res_t             right_res,
  output logic                       advance,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*SAMPLE_W-1:0]      out_tdata
);

  logic    vld_r;
  sample_t left_r;
  sample_t right_r;

  assign advance = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= left_res.valid && right_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_r  <= left_res.sample;
      right_r <= right_res.sample;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {right_r, left_r};

endmodule

`default_nettype wire

@@ src/stereo_feedback_delay.sv @@
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo feedback delay: two delay line lanes and an output register.
// ----------------------------------------------------------------------------
// A word accepted on in_tready passes the memory read, the feedback multiply
// and the output register before it shows on out_tvalid.
// Throughput: one word per cycle unless out_tready stalls; each lane's line
// memory does one read and one write per cycle; forwarding covers delays to one sample.
// Reset: synchronous on rst_n; the lines read as zero through a fill count,
// so no clearing pass runs and in_tready is high right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_delay import sfd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream, tdata: left_in [15:0], right_in [31:16].
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2*SAMPLE_W-1:0] in_tdata,
  // Output stream, tdata: left_out [15:0], right_out [31:16].
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [2*SAMPLE_W-1:0]     out_tdata,
  // Configuration writes.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  delay_t    left_delay_r;
  delay_t    right_delay_r;
  gain_t     gain_r;
  addr_t     wr_ptr_r;
  addr_t     fill_r;
  logic      advance;
  logic      accept;
  lane_ctl_t ctl;
  lane_res_t left_res;
  lane_res_t right_res;

  // The whole pipeline moves whenever the output register can take a word,
  // so no new word is accepted while a result waits there for out_tready.
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  assign ctl.advance = advance;
  assign ctl.accept  = accept;
  assign ctl.wr_ptr  = wr_ptr_r;
  assign ctl.fill    = fill_r;

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_delay_r  <= delay_t'(1);
      right_delay_r <= delay_t'(1);
      gain_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr))
        CFG_LEFT_DELAY:    left_delay_r  <= cfg_wdata[DELAY_W-1:0];
        CFG_RIGHT_DELAY:   right_delay_r <= cfg_wdata[DELAY_W-1:0];
        CFG_FEEDBACK_GAIN: gain_r        <= gain_t'(cfg_wdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Shared write pointer and fill count. An entry whose word has not been
  // written since reset reads as zero; the fill count tells which.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (accept) begin
      wr_ptr_r <= wr_ptr_r + 1'b1;
      if (fill_r != addr_t'(LINE_DEPTH - 1)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  sfd_lane u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .delay  (left_delay_r),
    .gain   (gain_r),
    .dry_in (sample_t'(in_tdata[SAMPLE_W-1:0])),
    .res    (left_res)
  );

  sfd_lane u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .delay  (right_delay_r),
    .gain   (gain_r),
    .dry_in (sample_t'(in_tdata[2*SAMPLE_W-1:SAMPLE_W])),
    .res    (right_res)
  );

  sfd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .left_res   (left_res),
    .right_res  (right_res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
